FILE: rtl/crc8rfc_pkg.sv
`timescale 1ns / 1ps

package crc8rfc_pkg;

	localparam int TOT_W = 13;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'h00;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_CMD = 2'd1,
		STAT_CRC = 2'd2,
		STAT_LEN = 2'd3
	} frame_status_t;

	typedef struct packed {
		logic              payload_valid;
		logic [7:0]        payload_byte;
		logic [TOT_W-1:0]  payload_offset;
		logic              frame_done;
		frame_status_t     frame_status;
		logic              response_done;
		logic              response_ok;
		logic [TOT_W-1:0]  total_length;
	} result_t;

	// one byte of CRC-8, MSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

FILE: rtl/crc8rfc_frame_ctl.sv
`timescale 1ns / 1ps

module crc8rfc_frame_ctl import crc8rfc_pkg::*; #(
	parameter int FRAME_BYTES = 256,
	parameter int MAX_FRAMES  = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [7:0] rx_byte,
	input  logic       response_start,
	input  logic [7:0] expected_command,
	output result_t    res
);

	localparam int PosW = $clog2(FRAME_BYTES);
	localparam int FrW  = $clog2(MAX_FRAMES + 1);
	localparam logic [7:0]      LenMax  = 8'(FRAME_BYTES - 3);
	localparam logic [PosW-1:0] PosLast = PosW'(FRAME_BYTES - 1);

	logic [PosW-1:0]  pos_q, pos_c, pos_d;
	logic [7:0]       len_q, len_d;
	logic             cmd_ok_q, cmd_ok_d;
	logic [7:0]       crc_q, crc_d;
	logic [FrW-1:0]   frames_q, frames_c, frames_d, frames_inc;
	logic [TOT_W-1:0] total_q, total_c, total_d;
	logic             fin_q, fin_c, fin_d;
	logic [8:0]       pos_x, len_p2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_q    <= '0;
			cmd_ok_q <= 1'b0;
			crc_q    <= CRC_INIT;
			frames_q <= '0;
			total_q  <= '0;
			fin_q    <= 1'b0;
		end else if (step_en) begin
			pos_q    <= pos_d;
			len_q    <= len_d;
			cmd_ok_q <= cmd_ok_d;
			crc_q    <= crc_d;
			frames_q <= frames_d;
			total_q  <= total_d;
			fin_q    <= fin_d;
		end
	end

	always_comb begin
		// a restart clears the response before the byte is handled
		pos_c    = response_start ? '0 : pos_q;
		frames_c = response_start ? '0 : frames_q;
		total_c  = response_start ? '0 : total_q;
		fin_c    = response_start ? 1'b0 : fin_q;

		pos_x      = {{(9 - PosW){1'b0}}, pos_c};
		len_p2     = {1'b0, len_q} + 9'd2;
		frames_inc = frames_c + FrW'(1);

		pos_d    = pos_c;
		len_d    = len_q;
		cmd_ok_d = cmd_ok_q;
		crc_d    = crc_q;
		frames_d = frames_c;
		total_d  = total_c;
		fin_d    = fin_c;

		res                = '0;
		res.frame_status   = STAT_OK;

		if (!fin_c) begin
			if (pos_c == '0) begin
				cmd_ok_d = (rx_byte == expected_command);
			end else if (pos_c == PosW'(1)) begin
				len_d = rx_byte;
				crc_d = crc8_step(CRC_INIT, rx_byte);
				if (rx_byte > LenMax) begin
					res.frame_done   = 1'b1;
					res.frame_status = STAT_LEN;
					fin_d            = 1'b1;
				end
			end else if (pos_x < len_p2) begin
				crc_d              = crc8_step(crc_q, rx_byte);
				res.payload_valid  = 1'b1;
				res.payload_byte   = rx_byte;
				res.payload_offset = total_c + TOT_W'(pos_x - 9'd2);
			end else if (pos_x == len_p2) begin
				res.frame_done = 1'b1;
				if (!cmd_ok_q) begin
					res.frame_status = STAT_CMD;
				end else if (rx_byte != crc_q) begin
					res.frame_status = STAT_CRC;
				end else begin
					total_d = total_c + TOT_W'(len_q);
				end
				frames_d = frames_inc;
				if (res.frame_status != STAT_OK || len_q < LenMax ||
				    frames_inc >= FrW'(MAX_FRAMES)) begin
					fin_d = 1'b1;
				end
			end
			// padding falls through; position wraps at the frame end
			pos_d = (pos_c == PosLast) ? '0 : pos_c + PosW'(1);
		end

		res.response_done = fin_d;
		res.response_ok   = (total_d != '0);
		res.total_length  = total_d;
	end

endmodule

FILE: rtl/crc8_response_frame_checker_top.sv
`timescale 1ns / 1ps
// A request is captured in the stage 1 register, then its result in the output register.
// Throughput: 1 request per cycle while out_stall is low; the CRC byte step and
// frame bookkeeping sit in one combinational pass between input and result registers.
// Reset (arst_n low, asynchronous): frame position, CRC, totals, frame count,
// finished flag, expected_command and both valid flags clear to zero.

module crc8_response_frame_checker_top import crc8rfc_pkg::*; #(
	parameter int FRAME_BYTES = 256,
	parameter int MAX_FRAMES  = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	// config
	input  logic             cfg_wr_en,
	input  logic [7:0]       cfg_wr_data,
	// request in
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte,
	input  logic             response_start,
	// result out
	output logic             out_valid,
	input  logic             out_stall,
	output logic             payload_valid,
	output logic [7:0]       payload_byte,
	output logic [TOT_W-1:0] payload_offset,
	output logic             frame_done,
	output logic [1:0]       frame_status,
	output logic             response_done,
	output logic             response_ok,
	output logic [TOT_W-1:0] total_length
);

	logic [7:0] expected_command_q;

	// stage 1: captured request
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       start_s1;

	// stage 2: result register
	logic       valid_s2;
	result_t    res_s2;
	result_t    res_c;

	logic adv;     // stage 2 can take a new result
	logic step_en; // the request in stage 1 is processed this cycle

	assign adv      = !valid_s2 || !out_stall;
	assign step_en  = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_command_q <= '0;
		end else if (cfg_wr_en) begin
			expected_command_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
			start_s1   <= response_start;
		end
	end

	// frame state machine and CRC; state advances only with step_en
	crc8rfc_frame_ctl #(
		.FRAME_BYTES(FRAME_BYTES),
		.MAX_FRAMES (MAX_FRAMES)
	) u_frame_ctl (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (step_en),
		.rx_byte         (rx_byte_s1),
		.response_start  (start_s1),
		.expected_command(expected_command_q),
		.res             (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid      = valid_s2;
	assign payload_valid  = res_s2.payload_valid;
	assign payload_byte   = res_s2.payload_byte;
	assign payload_offset = res_s2.payload_offset;
	assign frame_done     = res_s2.frame_done;
	assign frame_status   = res_s2.frame_status;
	assign response_done  = res_s2.response_done;
	assign response_ok    = res_s2.response_ok;
	assign total_length   = res_s2.total_length;

endmodule

FILE: rtl/crc8rfc_checker.sv
`timescale 1ns / 1ps

module crc8rfc_checker import crc8rfc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input logic             payload_valid,
	input logic [7:0]       payload_byte,
	input logic [TOT_W-1:0] payload_offset,
	input logic             frame_done,
	input logic [1:0]       frame_status,
	input logic             response_ok,
	input logic [TOT_W-1:0] total_length
);

	// a status other than ok only comes with a frame verdict
	a_status_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_done |-> frame_status == STAT_OK)
		else $error("frame_status set without frame_done");

	// payload bytes never land below the accepted total, and never share a verdict
	a_payload_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_valid |-> payload_offset >= total_length && !frame_done)
		else $error("payload offset below total or payload on verdict byte");

	a_ok_tracks_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> response_ok == (total_length != '0))
		else $error("response_ok disagrees with total_length");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte) &&
		$stable(payload_offset) && $stable(total_length))
		else $error("stalled result changed");

endmodule

bind crc8_response_frame_checker_top crc8rfc_checker u_crc8rfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.payload_valid (payload_valid),
	.payload_byte  (payload_byte),
	.payload_offset(payload_offset),
	.frame_done    (frame_done),
	.frame_status  (frame_status),
	.response_ok   (response_ok),
	.total_length  (total_length)
);
